### rtl/eight_bit_cpu_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 8-bit core
// Shared concurrent check forms used by the core's modules.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_CORE_MACROS_SVH
`define EIGHT_BIT_CPU_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define EBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define EBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg
// Types and constants shared by the 8-bit core modules.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_NUM   = 3'd2;
  localparam logic [2:0] KIND_ASCII = 3'd3;
  localparam logic [2:0] KIND_HALT  = 3'd4;

  localparam logic [15:0] DATA_BASE = 16'h8000;
  localparam logic [15:0] SP_RESET  = 16'hFE00;

  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_POP2   = 3'd5;

  localparam logic [7:0] OP_HLT  = 8'h01;
  localparam logic [7:0] OP_LDI  = 8'h02;
  localparam logic [7:0] OP_LD   = 8'h03;
  localparam logic [7:0] OP_ST   = 8'h04;
  localparam logic [7:0] OP_MOV  = 8'h05;
  localparam logic [7:0] OP_ADD  = 8'h06;
  localparam logic [7:0] OP_ADC  = 8'h07;
  localparam logic [7:0] OP_AND  = 8'h08;
  localparam logic [7:0] OP_JMP  = 8'h09;
  localparam logic [7:0] OP_OUT  = 8'h0A;
  localparam logic [7:0] OP_CMP  = 8'h0B;
  localparam logic [7:0] OP_JZ   = 8'h0C;
  localparam logic [7:0] OP_JNN  = 8'h0D;
  localparam logic [7:0] OP_LDR  = 8'h0E;
  localparam logic [7:0] OP_STR  = 8'h0F;
  localparam logic [7:0] OP_LDP  = 8'h10;
  localparam logic [7:0] OP_STP  = 8'h11;
  localparam logic [7:0] OP_ADDP = 8'h12;
  localparam logic [7:0] OP_ADDI = 8'h13;
  localparam logic [7:0] OP_OUTP = 8'h14;
  localparam logic [7:0] OP_OUTC = 8'h15;
  localparam logic [7:0] OP_OR   = 8'h16;
  localparam logic [7:0] OP_NOT  = 8'h17;
  localparam logic [7:0] OP_XOR  = 8'h18;
  localparam logic [7:0] OP_JN   = 8'h19;
  localparam logic [7:0] OP_CALL = 8'h20;
  localparam logic [7:0] OP_RET  = 8'h21;

  // Operand byte count; 3'd7 marks an opcode that does not exist.
  localparam logic [2:0] CNT_NONE = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [15:0] value;
  } access_t;

  // One captured input item handed from the front to the back part.
  typedef struct packed {
    logic [7:0] read_data;
    logic       kick;
  } item_t;

  function automatic logic [2:0] operand_count(input logic [7:0] op);
    logic [2:0] c;
    begin
      case (op)
        8'h00, OP_HLT, OP_RET: c = 3'd0;
        OP_MOV, OP_ADD, OP_ADC, OP_AND, OP_OUT, OP_LDR, OP_STR, OP_LDP,
        OP_STP, OP_OUTP, OP_OUTC, OP_OR, OP_NOT, OP_XOR: c = 3'd1;
        OP_LDI, OP_LD, OP_ST, OP_JMP, OP_CMP, OP_JZ, OP_JNN, OP_ADDI,
        OP_JN, OP_CALL: c = 3'd2;
        OP_ADDP: c = 3'd3;
        default: c = CNT_NONE;
      endcase
      return c;
    end
  endfunction

endpackage

### rtl/ebc_front.sv
// ----------------------------------------------------------------------------
// ebc_front
// Input skid queue: takes reply bytes and holds up to two of them for the
// execute part, keeping the input ready while results drain, until full.
// ----------------------------------------------------------------------------
module ebc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ebc_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output ebc_pkg::item_t q_item
);
  import ebc_pkg::*;

  item_t      slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_item;
  end

  `include "eight_bit_cpu_core_macros.svh"

  `EBC_ASSERT_IMPL(a_no_overflow, count == 2'd2, !push)
  `EBC_ASSERT_IMPL(a_no_underflow, count == 2'd0, !pop)
  `EBC_ASSERT_NEXT(a_count_grows, push && !pop && count == 2'd0, count == 2'd1)

endmodule

### rtl/ebc_back.sv
// ----------------------------------------------------------------------------
// ebc_back
// Execute part: decodes each byte against the fetch phase, updates the
// architectural state and plays out up to three accesses, one per ready cycle.
// ----------------------------------------------------------------------------
module ebc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  ebc_pkg::item_t    q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ebc_pkg::access_t  out_acc,
  output logic              out_last
);
  import ebc_pkg::*;

  logic [7:0]  regs [4];
  logic [3:0]  flags;
  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  opcode;
  logic [23:0] operands;
  logic [2:0]  phase;
  logic        stopped;

  // Result buffer: up to three accesses from one item.
  access_t     buf_acc [3];
  logic [1:0]  buf_num;
  logic [1:0]  buf_idx;

  // Next-state values.
  logic [7:0]  regs_next [4];
  logic [3:0]  flags_next;
  logic [15:0] pc_next;
  logic [15:0] sp_next;
  logic [7:0]  opcode_next;
  logic [23:0] operands_next;
  logic [2:0]  phase_next;
  logic        stopped_next;
  access_t     acc_next [3];
  logic [1:0]  num_next;

  logic        busy;
  logic        take;

  assign busy    = (buf_num != 2'd0);
  assign q_ready = !busy || (out_ready && (buf_idx == buf_num - 2'd1));
  assign take    = q_valid && q_ready;

  assign out_valid = busy;
  assign out_acc   = buf_acc[buf_idx];
  assign out_last  = busy && (buf_idx == buf_num - 2'd1);

  // Decode and execute one item.
  always_comb begin
    logic [7:0]  d;
    logic [7:0]  b0, b1, b2;
    logic [15:0] target, off16;
    logic [2:0]  cnt;
    logic [8:0]  sum9;
    logic [7:0]  ra, rb, rl;
    logic [16:0] sum17;
    logic [15:0] pair;
    logic [1:0]  pi;
    logic        run_exec;
    logic        do_fetch;

    d = q_item.read_data;
    b0     = '0;
    b1     = '0;
    b2     = '0;
    target = '0;
    off16  = '0;
    cnt    = '0;
    sum9   = '0;
    ra     = '0;
    rb     = '0;
    rl     = '0;
    sum17  = '0;
    pair   = '0;
    pi     = '0;
    for (int i = 0; i < 4; i++) regs_next[i] = regs[i];
    flags_next    = flags;
    pc_next       = pc;
    sp_next       = sp;
    opcode_next   = opcode;
    operands_next = operands;
    phase_next    = phase;
    stopped_next  = stopped;
    for (int i = 0; i < 3; i++) acc_next[i] = '0;
    num_next = 2'd0;
    run_exec = 1'b0;
    do_fetch = 1'b0;

    if (stopped) begin
      acc_next[0].kind = KIND_HALT;
      num_next = 2'd1;
    end else if (q_item.kick || phase > PH_POP2) begin
      phase_next = PH_OPCODE;
      operands_next = '0;
      do_fetch = 1'b1;
    end else if (phase == PH_OPCODE) begin
      opcode_next = d;
      operands_next = '0;
      cnt = operand_count(d);
      if (cnt == CNT_NONE || d == OP_HLT) begin
        stopped_next = 1'b1;
        acc_next[0].kind = KIND_HALT;
        num_next = 2'd1;
      end else if (cnt != 3'd0) begin
        phase_next = 3'd1;
        do_fetch = 1'b1;
      end else begin
        run_exec = 1'b1;
      end
    end else if (phase <= 3'd3) begin
      cnt = operand_count(opcode);
      case (phase)
        3'd1:    operands_next[7:0]   = d;
        3'd2:    operands_next[15:8]  = d;
        default: operands_next[23:16] = d;
      endcase
      if (cnt != CNT_NONE && phase < cnt) begin
        phase_next = phase + 3'd1;
        do_fetch = 1'b1;
      end else begin
        run_exec = 1'b1;
      end
    end else if (phase == PH_DATA) begin
      if (opcode == OP_RET) begin
        operands_next = {16'h0, d};
        sp_next = sp + 16'd1;
        phase_next = PH_POP2;
        acc_next[0].kind = KIND_READ;
        acc_next[0].address = sp + 16'd1;
        num_next = 2'd1;
      end else begin
        if (opcode == OP_LD) regs_next[operands[7:6]] = d;
        else if (opcode == OP_LDR) regs_next[operands[3:2]] = d;
        else if (opcode == OP_LDP) regs_next[operands[5:4]] = d;
        phase_next = PH_OPCODE;
        do_fetch = 1'b1;
      end
    end else begin
      pc_next = {operands[7:0], d};
      phase_next = PH_OPCODE;
      do_fetch = 1'b1;
    end

    // Instruction execution with the complete operand set.
    if (run_exec) begin
      b0 = operands_next[7:0];
      b1 = operands_next[15:8];
      b2 = operands_next[23:16];
      target = {1'b0, b0[6:0], b1};
      off16  = DATA_BASE + {2'b0, b0[5:0], b1};
      pi = {b0[0], 1'b0};
      pair = {regs[pi], regs[pi + 2'd1]};
      ra = regs[b0[1:0]];
      rb = regs[b0[3:2]];
      phase_next = PH_OPCODE;
      do_fetch = 1'b1;
      case (opcode_next)
        OP_LDI: regs_next[b0[1:0]] = b1;
        OP_LD: begin
          phase_next = PH_DATA;
          do_fetch = 1'b0;
          acc_next[0].kind = KIND_READ;
          acc_next[0].address = off16;
          num_next = 2'd1;
        end
        OP_ST: begin
          acc_next[0].kind = KIND_WRITE;
          acc_next[0].address = off16;
          acc_next[0].value = {8'h0, regs[b0[7:6]]};
          num_next = 2'd1;
        end
        OP_MOV: regs_next[b0[3:2]] = ra;
        OP_ADD, OP_ADC, OP_ADDI: begin
          if (opcode_next == OP_ADDI) begin
            sum9 = {1'b0, ra} + {1'b0, b1};
            flags_next[3] = (ra[7] == b1[7]) && (ra[7] != sum9[7]);
            regs_next[b0[1:0]] = sum9[7:0];
          end else begin
            sum9 = {1'b0, rb} + {1'b0, ra} +
                   {8'h0, (opcode_next == OP_ADC) && flags[0]};
            flags_next[3] = (rb[7] == ra[7]) && (rb[7] != sum9[7]);
            regs_next[b0[5:4]] = sum9[7:0];
          end
          flags_next[1] = (sum9[7:0] == 8'h0);
          flags_next[2] = sum9[7];
          flags_next[0] = sum9[8];
        end
        OP_AND, OP_OR, OP_NOT, OP_XOR: begin
          case (opcode_next)
            OP_AND:  rl = ra & rb;
            OP_OR:   rl = ra | rb;
            OP_XOR:  rl = ra ^ rb;
            default: rl = ~ra;
          endcase
          regs_next[b0[5:4]] = rl;
          flags_next[1] = (rl == 8'h0);
          flags_next[2] = rl[7];
        end
        OP_JMP: pc_next = target;
        OP_OUT, OP_OUTC: begin
          acc_next[0].kind = (opcode_next == OP_OUT) ? KIND_NUM : KIND_ASCII;
          acc_next[0].value = {8'h0, ra};
          num_next = 2'd1;
        end
        OP_CMP: begin
          rl = ra - b1;
          flags_next[1] = (rl == 8'h0);
          flags_next[2] = rl[7];
        end
        OP_JZ:  if (flags[1]) pc_next = target;
        OP_JNN: if (!flags[2]) pc_next = target;
        OP_JN:  if (flags[2]) pc_next = target;
        OP_LDR: begin
          phase_next = PH_DATA;
          do_fetch = 1'b0;
          acc_next[0].kind = KIND_READ;
          acc_next[0].address = DATA_BASE + {8'h0, ra};
          num_next = 2'd1;
        end
        OP_STR: begin
          acc_next[0].kind = KIND_WRITE;
          acc_next[0].address = DATA_BASE + {8'h0, ra};
          acc_next[0].value = {8'h0, rb};
          num_next = 2'd1;
        end
        OP_LDP: begin
          phase_next = PH_DATA;
          do_fetch = 1'b0;
          acc_next[0].kind = KIND_READ;
          acc_next[0].address = pair + DATA_BASE;
          num_next = 2'd1;
        end
        OP_STP: begin
          acc_next[0].kind = KIND_WRITE;
          acc_next[0].address = pair + DATA_BASE;
          acc_next[0].value = {8'h0, regs[b0[5:4]]};
          num_next = 2'd1;
        end
        OP_ADDP: begin
          sum17 = {1'b0, pair} + {1'b0, b1, b2};
          regs_next[pi] = sum17[15:8];
          regs_next[pi + 2'd1] = sum17[7:0];
          flags_next[1] = (sum17[15:0] == 16'h0);
          flags_next[2] = sum17[15];
          flags_next[0] = sum17[16];
        end
        OP_OUTP: begin
          acc_next[0].kind = KIND_NUM;
          acc_next[0].value = pair;
          num_next = 2'd1;
        end
        OP_CALL: begin
          acc_next[0].kind = KIND_WRITE;
          acc_next[0].address = sp;
          acc_next[0].value = {8'h0, pc[7:0]};
          acc_next[1].kind = KIND_WRITE;
          acc_next[1].address = sp - 16'd1;
          acc_next[1].value = {8'h0, pc[15:8]};
          num_next = 2'd2;
          sp_next = sp - 16'd2;
          pc_next = target;
        end
        OP_RET: begin
          phase_next = PH_DATA;
          do_fetch = 1'b0;
          sp_next = sp + 16'd1;
          acc_next[0].kind = KIND_READ;
          acc_next[0].address = sp + 16'd1;
          num_next = 2'd1;
        end
        default: ;
      endcase
    end

    // Closing fetch at the program counter.
    if (do_fetch) begin
      acc_next[num_next].kind = KIND_READ;
      acc_next[num_next].address = pc_next;
      acc_next[num_next].value = 16'h0;
      num_next = num_next + 2'd1;
      pc_next = pc_next + 16'd1;
    end
  end

  // Architectural state and result sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) regs[i] <= 8'h0;
      flags    <= 4'h0;
      pc       <= 16'h0;
      sp       <= SP_RESET;
      opcode   <= 8'h0;
      operands <= 24'h0;
      phase    <= PH_OPCODE;
      stopped  <= 1'b0;
      buf_num  <= 2'd0;
      buf_idx  <= 2'd0;
    end else if (take) begin
      for (int i = 0; i < 4; i++) regs[i] <= regs_next[i];
      flags    <= flags_next;
      pc       <= pc_next;
      sp       <= sp_next;
      opcode   <= opcode_next;
      operands <= operands_next;
      phase    <= phase_next;
      stopped  <= stopped_next;
      buf_num  <= num_next;
      buf_idx  <= 2'd0;
    end else if (busy && out_ready) begin
      if (out_last) buf_num <= 2'd0;
      else buf_idx <= buf_idx + 2'd1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 3; i++) buf_acc[i] <= acc_next[i];
    end
  end

  `include "eight_bit_cpu_core_macros.svh"

  `EBC_ASSERT_IMPL(a_idx_in_range, busy, buf_idx < buf_num)
  `EBC_ASSERT_NEXT(a_take_loads, take, buf_num != 2'd0 && buf_idx == 2'd0)
  `EBC_ASSERT_NEXT(a_stop_sticky, stopped, stopped)

endmodule

### rtl/eight_bit_cpu_core.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_core
// Small 8-bit processor core driven by memory reply bytes.
// ----------------------------------------------------------------------------
// Each input transaction is a byte answering the last read request, or a
// kick; the core answers with one to three access transactions, the final
// one flagged by tlast. A two-entry input queue decouples intake from the
// execute part, which takes a new input when idle or as the last result of
// the previous input is accepted, so the single result port of the execute
// part paces intake.
module eight_bit_cpu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] read_data
  input  logic        s_tuser,   // [0] kick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] access_kind, [18:3] address,
                                 // [34:19] value, [39:35] zero
  output logic        m_tlast
);
  import ebc_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  access_t acc;

  assign in_item.read_data = s_tdata;
  assign in_item.kick      = s_tuser;

  ebc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ebc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_acc   (acc),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b0, acc.value, acc.address, acc.kind};

endmodule

### tb/eight_bit_cpu_core_tb.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_core_tb
// Self-checking bench for the 8-bit core. A driver feeds memory reply bytes
// and kicks from a queue; an in-bench model of the core predicts every access
// transaction, and a monitor compares each output transaction against the
// oldest prediction. Both sides pause at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module eight_bit_cpu_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ebc_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] address;
    logic [15:0] value;
    logic        last;
  } access_exp_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  eight_bit_cpu_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state of the core.
  logic [7:0]  regs [4];
  logic [3:0]  flags;
  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  opcode;
  logic [23:0] operands;
  logic [2:0]  phase;
  logic        halted;

  access_exp_t expected_accesses[$];
  logic [8:0]  pending_replies[$];   // {kick, read_data}
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          holdoff_req = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  task automatic push_access(input logic [2:0] k, input logic [15:0] a,
                             input logic [15:0] v);
    access_exp_t e;
    e.kind = k;
    e.address = a;
    e.value = v;
    e.last = 1'b0;
    expected_accesses.push_back(e);
  endtask

  task automatic fetch_at_pc();
    push_access(KIND_READ, pc, 16'h0);
    pc = pc + 16'd1;
  endtask

  function automatic logic [2:0] opnd_count(input logic [7:0] op);
    case (op)
      8'h00, OP_HLT, OP_RET: return 3'd0;
      OP_MOV, OP_ADD, OP_ADC, OP_AND, OP_OUT, OP_LDR, OP_STR, OP_LDP,
      OP_STP, OP_OUTP, OP_OUTC, OP_OR, OP_NOT, OP_XOR: return 3'd1;
      OP_LDI, OP_LD, OP_ST, OP_JMP, OP_CMP, OP_JZ, OP_JNN, OP_ADDI,
      OP_JN, OP_CALL: return 3'd2;
      OP_ADDP: return 3'd3;
      default: return CNT_NONE;
    endcase
  endfunction

  task automatic set_zn(input logic [7:0] r);
    flags[1] = (r == 8'h00);
    flags[2] = r[7];
  endtask

  task automatic add_bytes(input logic [1:0] d, input logic [7:0] a,
                           input logic [7:0] b, input logic cin);
    logic [8:0] r;
    r = {1'b0, a} + {1'b0, b} + {8'h0, cin};
    flags[3] = ((a ^ ~b) & (a ^ r[7:0]) & 8'h80) != 0;
    set_zn(r[7:0]);
    flags[0] = r[8];
    regs[d] = r[7:0];
  endtask

  function automatic logic [15:0] pair_of(input logic [7:0] b);
    return b[0] ? {regs[2], regs[3]} : {regs[0], regs[1]};
  endfunction

  // Carry out a complete instruction and predict its accesses.
  task automatic run_instruction();
    logic [7:0]  b0, b1, b2;
    logic [15:0] tgt, off, sum16;
    logic [16:0] psum;
    logic [7:0]  r;
    b0 = operands[7:0];
    b1 = operands[15:8];
    b2 = operands[23:16];
    tgt = {1'b0, b0[6:0], b1};
    off = {2'b0, b0[5:0], b1};
    case (opcode)
      OP_LDI: regs[b0[1:0]] = b1;
      OP_LD: begin
        phase = PH_DATA;
        push_access(KIND_READ, DATA_BASE + off, 16'h0);
        return;
      end
      OP_ST: push_access(KIND_WRITE, DATA_BASE + off, {8'h0, regs[b0[7:6]]});
      OP_MOV: regs[b0[3:2]] = regs[b0[1:0]];
      OP_ADD, OP_ADC:
        add_bytes(b0[5:4], regs[b0[3:2]], regs[b0[1:0]],
                  (opcode == OP_ADC) && flags[0]);
      OP_AND, OP_OR, OP_NOT, OP_XOR: begin
        if (opcode == OP_AND) r = regs[b0[1:0]] & regs[b0[3:2]];
        else if (opcode == OP_OR) r = regs[b0[1:0]] | regs[b0[3:2]];
        else if (opcode == OP_XOR) r = regs[b0[1:0]] ^ regs[b0[3:2]];
        else r = ~regs[b0[1:0]];
        regs[b0[5:4]] = r;
        set_zn(r);
      end
      OP_JMP: pc = tgt;
      OP_OUT: push_access(KIND_NUM, 16'h0, {8'h0, regs[b0[1:0]]});
      OP_CMP: set_zn(regs[b0[1:0]] - b1);
      OP_JZ: if (flags[1]) pc = tgt;
      OP_JNN: if (!flags[2]) pc = tgt;
      OP_JN: if (flags[2]) pc = tgt;
      OP_LDR: begin
        phase = PH_DATA;
        push_access(KIND_READ, DATA_BASE + {8'h0, regs[b0[1:0]]}, 16'h0);
        return;
      end
      OP_STR: push_access(KIND_WRITE, DATA_BASE + {8'h0, regs[b0[1:0]]},
                          {8'h0, regs[b0[3:2]]});
      OP_LDP: begin
        phase = PH_DATA;
        push_access(KIND_READ, pair_of(b0) + DATA_BASE, 16'h0);
        return;
      end
      OP_STP: push_access(KIND_WRITE, pair_of(b0) + DATA_BASE, {8'h0, regs[b0[5:4]]});
      OP_ADDP: begin
        psum = {1'b0, pair_of(b0)} + {1'b0, b1, b2};
        sum16 = psum[15:0];
        if (b0[0]) begin
          regs[2] = sum16[15:8];
          regs[3] = sum16[7:0];
        end else begin
          regs[0] = sum16[15:8];
          regs[1] = sum16[7:0];
        end
        flags[1] = (sum16 == 16'h0);
        flags[2] = sum16[15];
        flags[0] = psum[16];
      end
      OP_ADDI: add_bytes(b0[1:0], regs[b0[1:0]], b1, 1'b0);
      OP_OUTP: push_access(KIND_NUM, 16'h0, pair_of(b0));
      OP_OUTC: push_access(KIND_ASCII, 16'h0, {8'h0, regs[b0[1:0]]});
      OP_CALL: begin
        push_access(KIND_WRITE, sp, {8'h0, pc[7:0]});
        sp = sp - 16'd1;
        push_access(KIND_WRITE, sp, {8'h0, pc[15:8]});
        sp = sp - 16'd1;
        pc = tgt;
      end
      OP_RET: begin
        sp = sp + 16'd1;
        phase = PH_DATA;
        push_access(KIND_READ, sp, 16'h0);
        return;
      end
      default: ;
    endcase
    phase = PH_OPCODE;
    fetch_at_pc();
  endtask

  // Predict the accesses caused by one accepted reply or kick.
  task automatic predict_reply(input logic [7:0] d, input logic kick);
    logic [2:0] cnt;
    if (halted) begin
      push_access(KIND_HALT, 16'h0, 16'h0);
    end else if (kick || phase > PH_POP2) begin
      phase = PH_OPCODE;
      operands = '0;
      fetch_at_pc();
    end else if (phase == PH_OPCODE) begin
      opcode = d;
      operands = '0;
      cnt = opnd_count(d);
      if (cnt == CNT_NONE || d == OP_HLT) begin
        halted = 1'b1;
        push_access(KIND_HALT, 16'h0, 16'h0);
      end else if (cnt > 0) begin
        phase = 3'd1;
        fetch_at_pc();
      end else begin
        run_instruction();
      end
    end else if (phase <= 3'd3) begin
      cnt = opnd_count(opcode);
      operands = operands | (24'(d) << (8 * (phase - 1)));
      if (cnt != CNT_NONE && phase < cnt) begin
        phase = phase + 3'd1;
        fetch_at_pc();
      end else begin
        run_instruction();
      end
    end else if (phase == PH_DATA) begin
      if (opcode == OP_RET) begin
        operands = {16'h0, d};
        sp = sp + 16'd1;
        phase = PH_POP2;
        push_access(KIND_READ, sp, 16'h0);
      end else begin
        if (opcode == OP_LD) regs[operands[7:6]] = d;
        else if (opcode == OP_LDR) regs[operands[3:2]] = d;
        else if (opcode == OP_LDP) regs[operands[5:4]] = d;
        phase = PH_OPCODE;
        fetch_at_pc();
      end
    end else begin
      pc = {operands[7:0], d};
      phase = PH_OPCODE;
      fetch_at_pc();
    end
    expected_accesses[$].last = 1'b1;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: one transaction per handshake, random gaps between them.
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h0;
      s_tuser <= 1'b0;
      drv_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_reply(s_tdata, s_tuser);
        drv_gap = gap_len();
      end
      if (!s_tvalid || s_tready) begin
        if (drv_gap == 0 && pending_replies.size() > 0) begin
          logic [8:0] it;
          it = pending_replies.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= it[8];
          s_tdata <= it[7:0];
        end else begin
          s_tvalid <= 1'b0;
          if (drv_gap > 0) drv_gap = drv_gap - 1;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  int rcv_gap = 0;
  int holdoff_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (holdoff_req && holdoff_left == 0) begin
        holdoff_left = 200;
        holdoff_req = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left = holdoff_left - 1;
        m_tready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap = rcv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rcv_gap = gap_len();
      end
    end
  end

  // Monitor: compare each output transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        access_exp_t e;
        if (expected_accesses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected access: kind %0d addr %h value %h last %b",
                     m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast);
        end else begin
          e = expected_accesses.pop_front();
          if (m_tdata[2:0] !== e.kind || m_tdata[18:3] !== e.address ||
              m_tdata[34:19] !== e.value || m_tlast !== e.last ||
              m_tdata[39:35] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("access mismatch: exp kind %0d addr %h value %h last %b, got kind %0d addr %h value %h last %b",
                       e.kind, e.address, e.value, e.last,
                       m_tdata[2:0], m_tdata[18:3], m_tdata[34:19], m_tlast);
          end
        end
      end
    end
  end

  // Watchdog over cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("eight_bit_cpu_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_reply(input logic [7:0] d);
    pending_replies.push_back({1'b0, d});
  endtask

  task automatic add_kick();
    pending_replies.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  // Build a random well-formed instruction; every opcode drawn is valid.
  task automatic add_instruction();
    logic [7:0] op;
    int n;
    case ($urandom_range(0, 5))
      0: op = 8'h00;
      1: op = OP_RET;
      default: op = 8'($urandom_range(2, 32));
    endcase
    if (op > 8'h19 && op < 8'h20) op = OP_CALL;
    add_reply(op);
    n = opnd_count(op);
    for (int i = 0; i < n; i++) add_reply(8'($urandom_range(0, 255)));
    // Data read and pop replies, where the instruction asks for them.
    if (op == OP_LD || op == OP_LDR || op == OP_LDP) add_reply(8'($urandom_range(0, 255)));
    if (op == OP_RET) begin
      add_reply(8'($urandom_range(0, 255)));
      add_reply(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    while (pending_replies.size() > 0 || s_tvalid || expected_accesses.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    regs = '{default: 8'h0};
    flags = 4'h0;
    pc = 16'h0;
    sp = SP_RESET;
    opcode = 8'h0;
    operands = '0;
    phase = PH_OPCODE;
    halted = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: replies before any kick, then a selection of operations.
    add_reply(OP_LDI); add_reply(8'h01); add_reply(8'hFF);
    add_kick();
    add_reply(OP_LDI); add_reply(8'h00); add_reply(8'h7F);
    add_reply(OP_ADD); add_reply(8'h21);                  // carry out, result into R2
    add_reply(OP_ADC); add_reply(8'h35);
    add_reply(OP_NOT); add_reply(8'h10);
    add_reply(OP_OUTP); add_reply(8'h01);
    add_reply(OP_OUTC); add_reply(8'h03);
    add_reply(OP_ADDP); add_reply(8'h00); add_reply(8'hFF); add_reply(8'hFF);
    add_reply(OP_LD); add_reply(8'hFF); add_reply(8'hFF); add_reply(8'hA5);
    add_reply(OP_CALL); add_reply(8'hFF); add_reply(8'hFF);
    add_reply(OP_RET); add_reply(8'h12); add_reply(8'h34);
    add_reply(OP_JMP); add_kick();                        // kick mid-instruction

    // Random well-formed programs, some cut short by a kick; one long
    // receiver hold-off.
    for (int i = 0; i < 140; i++) begin
      if (i == 40) holdoff_req = 1;
      if ($urandom_range(0, 19) == 0) add_kick();
      else if ($urandom_range(0, 29) == 0) begin
        add_reply(OP_LDI);
        add_reply(8'($urandom_range(0, 255)));
        add_kick();
      end
      else add_instruction();
    end
    wait_drained();

    // Halt: an unknown opcode, then a kick and data bytes all stay halted.
    add_reply(8'hFF);
    add_kick();
    add_reply(8'h00);
    add_reply(OP_HLT);
    wait_drained();

    if (mismatches == 0 && expected_accesses.size() == 0) begin
      $display("eight_bit_cpu_core test passed");
    end else begin
      $display("eight_bit_cpu_core test failed");
    end
    $finish;
  end
endmodule
